/* src/xoshiro256pp_range_generator_macros.svh */
// ----------------------------------------------------------------------------
// xoshiro256pp_range_generator_macros
// Assertion macros shared by the generator's RTL files.
// Both expect a clock named clk and an active-high reset named rst.
// ----------------------------------------------------------------------------
`ifndef XOSHIRO256PP_RANGE_GENERATOR_MACROS_SVH
`define XOSHIRO256PP_RANGE_GENERATOR_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define XRG_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication
`define XRG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`else

`define XRG_ASSERT_IMPL(lbl, ante, cons)
`define XRG_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* src/xrg_pkg.sv */
// ----------------------------------------------------------------------------
// xrg_pkg
// Types, constants and command/status structs of the xoshiro256++ range
// generator.
// ----------------------------------------------------------------------------
`default_nettype none

package xrg_pkg;

  // default upper bound on outputs per draw
  localparam int MAX_DRAWS_DEF = 64;

  // splitmix64 constants
  localparam logic [63:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_B   = 64'h94D0_49BB_1331_11EB;

  // item kinds
  localparam logic KIND_DRAW = 1'b0;
  localparam logic KIND_SEED = 1'b1;

  // configuration register indexes
  localparam logic REG_RANGE_MIN = 1'b0;
  localparam logic REG_RANGE_MAX = 1'b1;

  // input item
  typedef struct packed {
    logic        kind;
    logic [63:0] seed;
    logic [6:0]  draw_count;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [63:0] value;
    logic        last;
    logic        range_empty;
  } out_item_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_ADD,
    ST_MIXA_MUL,
    ST_MIXA_WAIT,
    ST_MIXB_SET,
    ST_MIXB_MUL,
    ST_MIXB_WAIT,
    ST_SEED_STORE,
    ST_GEN,
    ST_SCALE_MUL,
    ST_SCALE_WAIT,
    ST_EMIT,
    ST_EMPTY
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       seed_load;
    logic       seed_step;
    logic       mix2;
    logic       seed_store;
    logic [1:0] word_sel;
    logic       gen;
    logic       mul_clr;
    logic       mul_pp;
    logic [1:0] pp_sel;
    logic       emit;
    logic       emit_last;
    logic       emit_empty;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic range_empty;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

/* src/xrg_datapath.sv */
// ----------------------------------------------------------------------------
// xrg_datapath
// State words, range registers, shared 32x32 multiplier with 128-bit
// accumulator, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "xoshiro256pp_range_generator_macros.svh"

module xrg_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [63:0]       cfg_data,
  input  wire logic [63:0]       seed,
  input  wire xrg_pkg::cmd_t     cmd,
  output xrg_pkg::status_t       status,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output xrg_pkg::out_item_t     out_data
);
  import xrg_pkg::*;

  logic [63:0]  range_min;
  logic [63:0]  range_max;
  logic [63:0]  st [4];
  logic [63:0]  mix_acc;
  logic [63:0]  mul_a;
  logic [63:0]  mul_b;
  logic         span_full;
  logic [63:0]  prod;
  logic [1:0]   prod_sel;
  logic         prod_vld;
  logic [127:0] acc;

  logic [63:0]  mix_sum;
  logic [63:0]  acc_lo;
  logic [63:0]  span;
  logic [63:0]  sum03;
  logic [63:0]  gen_r;
  logic [63:0]  t17;
  logic [63:0]  s2x;
  logic [63:0]  s3x;
  logic [31:0]  a_half;
  logic [31:0]  b_half;
  logic [63:0]  pp;
  logic [127:0] pp_shifted;
  logic [63:0]  scaled;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      range_min <= '0;
      range_max <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RANGE_MIN: range_min <= cfg_data;
        REG_RANGE_MAX: range_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // status toward the controller
  assign status.range_empty = (range_min >= range_max);
  assign status.out_free    = !out_valid || out_ready;

  // splitmix64 and xoshiro256++ step logic
  assign mix_sum = mix_acc + GOLDEN_STEP;
  assign acc_lo  = acc[63:0];
  assign span    = range_max - range_min + 64'd1;
  assign sum03   = st[0] + st[3];
  assign gen_r   = {sum03[40:0], sum03[63:41]} + st[0];
  assign t17     = {st[1][46:0], 17'b0};
  assign s2x     = st[2] ^ st[0];
  assign s3x     = st[3] ^ st[1];

  // generator state words
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        st[i] <= '0;
      end
    end else if (cmd.seed_store) begin
      st[cmd.word_sel] <= acc_lo ^ (acc_lo >> 31);
    end else if (cmd.gen) begin
      st[0] <= st[0] ^ s3x;
      st[1] <= st[1] ^ s2x;
      st[2] <= s2x ^ t17;
      st[3] <= {s3x[18:0], s3x[63:19]};
    end
  end

  // multiplier operands and seed accumulator
  always_ff @(posedge clk) begin
    if (cmd.seed_load) begin
      mix_acc <= seed;
    end else if (cmd.seed_step) begin
      mix_acc <= mix_sum;
    end
    if (cmd.seed_step) begin
      mul_a <= mix_sum ^ (mix_sum >> 30);
      mul_b <= MIX_MUL_A;
    end else if (cmd.mix2) begin
      mul_a <= acc_lo ^ (acc_lo >> 27);
      mul_b <= MIX_MUL_B;
    end else if (cmd.gen) begin
      mul_a     <= gen_r;
      mul_b     <= span;
      span_full <= (span == 64'd0);
    end
  end

  // partial product select: bit 1 picks the half of a, bit 0 the half of b
  assign a_half = cmd.pp_sel[1] ? mul_a[63:32] : mul_a[31:0];
  assign b_half = cmd.pp_sel[0] ? mul_b[63:32] : mul_b[31:0];
  assign pp     = a_half * b_half;

  always_comb begin
    case (prod_sel)
      2'd0:    pp_shifted = {64'b0, prod};
      2'd3:    pp_shifted = {prod, 64'b0};
      default: pp_shifted = {32'b0, prod, 32'b0};
    endcase
  end

  // product register, valid flag is control
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= cmd.mul_pp;
    end
    prod     <= pp;
    prod_sel <= cmd.pp_sel;
  end

  // 128-bit accumulator
  always_ff @(posedge clk) begin
    if (cmd.mul_clr) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + pp_shifted;
    end
  end

  // result register
  assign scaled = span_full ? mul_a : acc[127:64];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.emit_empty) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.emit) begin
      out_data.value       <= range_min + scaled;
      out_data.last        <= cmd.emit_last;
      out_data.range_empty <= 1'b0;
    end else if (cmd.emit_empty) begin
      out_data.value       <= range_min;
      out_data.last        <= 1'b1;
      out_data.range_empty <= 1'b1;
    end
  end

  // accumulator is never cleared while a partial product is pending
  `XRG_ASSERT_IMPL(a_clr_no_pending, cmd.mul_clr, !prod_vld)

endmodule

`default_nettype wire

/* src/xrg_ctrl.sv */
// ----------------------------------------------------------------------------
// xrg_ctrl
// Sequencer for seeding, partial-product multiplies and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

`include "xoshiro256pp_range_generator_macros.svh"

module xrg_ctrl #(
  parameter int MAX_DRAWS = xrg_pkg::MAX_DRAWS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_kind,
  input  wire logic [6:0]       in_draw_count,
  input  wire xrg_pkg::status_t status,
  output xrg_pkg::cmd_t         cmd
);
  import xrg_pkg::*;

  localparam int CNT_MAX = (MAX_DRAWS < 127) ? MAX_DRAWS : 127;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);

  state_t           state;
  state_t           state_next;
  logic [1:0]       pp_cnt;
  logic [1:0]       w_cnt;
  logic [CNT_W-1:0] cnt;
  logic             accept;
  logic             is_last;

  assign accept  = in_valid && in_ready;
  assign is_last = (cnt == CNT_W'(1));

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_SEED) begin
            state_next = ST_SEED_ADD;
          end else if (in_draw_count == 7'd0) begin
            state_next = ST_IDLE;
          end else if (status.range_empty) begin
            state_next = ST_EMPTY;
          end else begin
            state_next = ST_GEN;
          end
        end
      end
      ST_SEED_ADD:   state_next = ST_MIXA_MUL;
      ST_MIXA_MUL:   if (pp_cnt == 2'd3) state_next = ST_MIXA_WAIT;
      ST_MIXA_WAIT:  state_next = ST_MIXB_SET;
      ST_MIXB_SET:   state_next = ST_MIXB_MUL;
      ST_MIXB_MUL:   if (pp_cnt == 2'd3) state_next = ST_MIXB_WAIT;
      ST_MIXB_WAIT:  state_next = ST_SEED_STORE;
      ST_SEED_STORE: state_next = (w_cnt == 2'd3) ? ST_IDLE : ST_SEED_ADD;
      ST_GEN:        state_next = ST_SCALE_MUL;
      ST_SCALE_MUL:  if (pp_cnt == 2'd3) state_next = ST_SCALE_WAIT;
      ST_SCALE_WAIT: state_next = ST_EMIT;
      ST_EMIT: begin
        if (status.out_free) begin
          state_next = is_last ? ST_IDLE : ST_GEN;
        end
      end
      ST_EMPTY:      if (status.out_free) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.seed_load = in_valid;
      end
      ST_SEED_ADD: begin
        cmd.seed_step = 1'b1;
        cmd.mul_clr   = 1'b1;
      end
      ST_MIXB_SET: begin
        cmd.mix2    = 1'b1;
        cmd.mul_clr = 1'b1;
      end
      ST_MIXA_MUL, ST_MIXB_MUL, ST_SCALE_MUL: begin
        cmd.mul_pp = 1'b1;
        cmd.pp_sel = pp_cnt;
      end
      ST_SEED_STORE: begin
        cmd.seed_store = 1'b1;
        cmd.word_sel   = w_cnt;
      end
      ST_GEN: begin
        cmd.gen     = 1'b1;
        cmd.mul_clr = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit      = status.out_free;
        cmd.emit_last = is_last;
      end
      ST_EMPTY: begin
        cmd.emit_empty = status.out_free;
      end
      default: ;
    endcase
  end

  // partial product, seed word and draw counters
  always_ff @(posedge clk) begin
    if (rst) begin
      pp_cnt <= '0;
      w_cnt  <= '0;
      cnt    <= '0;
    end else begin
      pp_cnt <= cmd.mul_pp ? pp_cnt + 2'd1 : 2'd0;
      if (accept) begin
        w_cnt <= '0;
      end else if (cmd.seed_store) begin
        w_cnt <= w_cnt + 2'd1;
      end
      if (accept) begin
        if (32'(in_draw_count) > MAX_DRAWS) begin
          cnt <= CNT_W'(MAX_DRAWS);
        end else begin
          cnt <= CNT_W'(in_draw_count);
        end
      end else if (cmd.emit) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  // a result is only loaded into a free output register
  `XRG_ASSERT_IMPL(a_emit_free, cmd.emit || cmd.emit_empty, status.out_free)
  // a draw step never runs with an exhausted count
  `XRG_ASSERT_IMPL(a_gen_count, cmd.gen, cnt != '0)
  // the final result of a draw returns the sequencer to idle
  `XRG_ASSERT_NEXT(a_last_idle, cmd.emit && cmd.emit_last, state == ST_IDLE)
  // at most one datapath operation per cycle
  `XRG_ASSERT_IMPL(a_one_op, 1'b1,
    $onehot0({cmd.seed_step, cmd.mix2, cmd.seed_store, cmd.gen, cmd.emit, cmd.emit_empty}))

endmodule

`default_nettype wire

/* src/xoshiro256pp_range_generator.sv */
// ----------------------------------------------------------------------------
// xoshiro256pp_range_generator
// xoshiro256++ generator with splitmix64 seeding and range scaling.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid/in_ready/in_data): a seed item (kind 1) loads the
//   four state words from four splitmix64 outputs and produces no result;
//   a draw item (kind 0) produces min(draw_count, MAX_DRAWS) results, the
//   last one flagged. A draw count of zero produces nothing.
//   out channel (out_valid/out_ready/out_data): one transfer per result.
//   If range_min >= range_max a draw gives one result with value range_min,
//   last and range_empty set, and the state is left alone.
//   cfg port: cfg_we/cfg_index/cfg_data write range_min (0) and range_max (1);
//   the user must write them only while the block is idle; the block does not enforce it.
// Sequence: in_ready is high only while idle, so a new item is taken only
//   after the last one is done. A seed runs four rounds of two multiplies,
//   each 4 partial products through the single 32x32 multiplier plus an
//   accumulate step. Each draw result is a generator step and one 4-pass
//   multiply for the scaling, then a load into the output register.
// Reset: state words zero (a draw then returns range_min + 0), range_min 0,
//   range_max all ones, no result pending.
// Stall: the output register holds a result until taken; the sequencer
//   waits at that point while out_ready is low.
// ----------------------------------------------------------------------------
`default_nettype none

module xoshiro256pp_range_generator #(
  parameter int MAX_DRAWS = xrg_pkg::MAX_DRAWS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire xrg_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output xrg_pkg::out_item_t      out_data,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [63:0]        cfg_data
);
  import xrg_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  xrg_ctrl #(
    .MAX_DRAWS (MAX_DRAWS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_data.kind),
    .in_draw_count (in_data.draw_count),
    .status        (status),
    .cmd           (cmd)
  );

  // datapath
  xrg_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .seed      (in_data.seed),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the xoshiro256++ range generator. Reseed and draw
// requests go in through a bursty sender. A stalling receiver takes the
// results. Each transfer on the input side runs through a local model of the
// generator: splitmix64 seeding, the xoshiro256++ step, and range scaling by
// the high half of the 128-bit product. Results come out in order and are
// checked field by field. The range registers are rewritten between phases,
// while the block is idle, and cover full, narrow, empty and random ranges.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import xrg_pkg::*;

  localparam int          DRAW_LIMIT    = 64;
  localparam int          SETTLE_CYCLES = 80;       // outlasts a reseed
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam logic [63:0] GOLDEN        = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_A         = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_B         = 64'h94D049BB133111EB;
  localparam logic [63:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;

  logic        clk;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = REG_RANGE_MIN;
  logic [63:0] cfg_data  = '0;

  // local copy of the generator
  logic [63:0] xo_state [4] = '{default: '0};
  logic [63:0] lim_min = '0;
  logic [63:0] lim_max = ALL_ONES;

  in_item_t    requests_waiting [$];
  out_item_t   draws_owed [$];
  int          items_queued = 0;
  int          items_taken  = 0;
  int          results_seen = 0;
  int          mismatches   = 0;
  logic        in_taken     = 1'b0;
  int unsigned cycles       = 0;

  xoshiro256pp_range_generator #(.MAX_DRAWS(DRAW_LIMIT)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] rotl(input logic [63:0] v, input int n);
    return (v << n) | (v >> (64 - n));
  endfunction

  // splitmix64 output for an already advanced accumulator
  function automatic logic [63:0] mix64(input logic [63:0] z_in);
    logic [63:0] z;
    z = z_in;
    z = (z ^ (z >> 30)) * MIX_A;
    z = (z ^ (z >> 27)) * MIX_B;
    return z ^ (z >> 31);
  endfunction

  // one xoshiro256++ output, state advances
  function automatic logic [63:0] step_generator();
    logic [63:0] r;
    logic [63:0] t;
    r = rotl(xo_state[0] + xo_state[3], 23) + xo_state[0];
    t = xo_state[1] << 17;
    xo_state[2] = xo_state[2] ^ xo_state[0];
    xo_state[3] = xo_state[3] ^ xo_state[1];
    xo_state[1] = xo_state[1] ^ xo_state[2];
    xo_state[0] = xo_state[0] ^ xo_state[3];
    xo_state[2] = xo_state[2] ^ t;
    xo_state[3] = rotl(xo_state[3], 45);
    return r;
  endfunction

  // work out the results of one accepted request
  task automatic run_request(input in_item_t item);
    logic [63:0]  acc;
    logic [64:0]  span;
    logic [128:0] prod;
    logic [63:0]  raw;
    out_item_t    res;
    int           n;
    if (item.kind == KIND_SEED) begin
      acc = item.seed;
      for (int w = 0; w < 4; w++) begin
        acc = acc + GOLDEN;
        xo_state[w] = mix64(acc);
      end
    end else if (item.draw_count != 0) begin
      n = (item.draw_count > DRAW_LIMIT) ? DRAW_LIMIT : int'(item.draw_count);
      if (lim_min >= lim_max) begin
        res.value       = lim_min;
        res.last        = 1'b1;
        res.range_empty = 1'b1;
        draws_owed.push_back(res);
      end else begin
        // span of 2^64 gives the raw output back
        span = {1'b0, lim_max} - {1'b0, lim_min} + 65'd1;
        for (int i = 0; i < n; i++) begin
          raw             = step_generator();
          prod            = raw * span;
          res.value       = lim_min + prod[127:64];
          res.last        = (i == n - 1);
          res.range_empty = 1'b0;
          draws_owed.push_back(res);
        end
      end
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_item_t make_item(input logic k, input logic [63:0] s,
                                         input logic [6:0] c);
    in_item_t it;
    it.kind       = k;
    it.seed       = s;
    it.draw_count = c;
    return it;
  endfunction

  // mostly short draws, some long ones, occasional reseeds
  function automatic in_item_t random_request();
    in_item_t it;
    int       pick;
    it.seed = rand64();
    it.kind = ($urandom_range(0, 99) < 15) ? KIND_SEED : KIND_DRAW;
    pick    = $urandom_range(0, 99);
    if (pick < 60)
      it.draw_count = 7'($urandom_range(1, 16));
    else if (pick < 85)
      it.draw_count = 7'($urandom_range(17, 64));
    else
      it.draw_count = 7'($urandom_range(0, 127));
    return it;
  endfunction

  task automatic queue_request(input in_item_t item);
    requests_waiting.push_back(item);
    items_queued++;
  endtask

  task automatic write_reg(input logic idx, input logic [63:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // every request taken, every result back, reseed finished
  task automatic wait_idle();
    while (items_taken != items_queued || draws_owed.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // request sender: bursts of random length, random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (requests_waiting.size() != 0) begin
        in_data  <= requests_waiting.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left = burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver: stall pattern by segment, one long hold-off
  int   seg_left   = 0;
  int   stall_mode = 0;
  int   hold_left  = 0;
  logic hold_done  = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen >= 500) begin
      hold_done = 1'b1;
      hold_left = 400;
      out_ready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_left   = $urandom_range(10, 120);
        stall_mode = $urandom_range(0, 3);
      end
      seg_left = seg_left - 1;
      case (stall_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= ($urandom_range(0, 1) == 1);
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // monitor: register writes, result check, request prediction
  always @(posedge clk) begin
    out_item_t want;
    in_taken = in_valid && in_ready && !rst;
    if (!rst) begin
      if (cfg_we) begin
        if (cfg_index == REG_RANGE_MIN)
          lim_min = cfg_data;
        else
          lim_max = cfg_data;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (draws_owed.size() == 0) begin
          $error("result with nothing outstanding: value %h last %b range_empty %b",
                 out_data.value, out_data.last, out_data.range_empty);
          mismatches++;
        end else begin
          want = draws_owed.pop_front();
          if (out_data.value !== want.value) begin
            $error("value: expected %h, got %h", want.value, out_data.value);
            mismatches++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_data.last);
            mismatches++;
          end
          if (out_data.range_empty !== want.range_empty) begin
            $error("range_empty: expected %b, got %b", want.range_empty,
                   out_data.range_empty);
            mismatches++;
          end
        end
      end
      if (in_taken) begin
        items_taken++;
        run_request(in_data);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [63:0] lo;
    logic [63:0] hi;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset range: unseeded zeros, zero count, count extremes, ignored fields
    queue_request(make_item(KIND_DRAW, '0, 7'd3));
    queue_request(make_item(KIND_DRAW, '0, 7'd0));
    queue_request(make_item(KIND_SEED, '0, 7'd0));
    queue_request(make_item(KIND_DRAW, '0, 7'd1));
    queue_request(make_item(KIND_SEED, ALL_ONES, 7'd0));
    queue_request(make_item(KIND_DRAW, '0, 7'd64));
    queue_request(make_item(KIND_DRAW, '0, 7'd65));
    queue_request(make_item(KIND_DRAW, '0, 7'd127));
    queue_request(make_item(KIND_SEED, rand64(), 7'd127));
    queue_request(make_item(KIND_DRAW, ALL_ONES, 7'd2));
    wait_idle();

    // min equal to max: one flagged result, state untouched
    write_reg(REG_RANGE_MIN, '0);
    write_reg(REG_RANGE_MAX, '0);
    queue_request(make_item(KIND_DRAW, '0, 7'd1));
    queue_request(make_item(KIND_DRAW, '0, 7'd0));
    queue_request(make_item(KIND_DRAW, ALL_ONES, 7'd127));
    queue_request(make_item(KIND_SEED, rand64(), 7'd5));
    queue_request(make_item(KIND_DRAW, '0, 7'd5));

    // random phases over a set of ranges
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      case (p)
        0: begin lo = '0;                hi = ALL_ONES; end
        1: begin lo = ALL_ONES - 64'd1;  hi = ALL_ONES; end
        2: begin lo = rand64();          hi = rand64(); end
        3: begin lo = ALL_ONES;          hi = '0;       end
        4: begin lo = ALL_ONES;          hi = ALL_ONES; end
        5: begin
          lo = rand64() >> 1;
          hi = lo + 64'($urandom_range(1, 1000));
        end
        6: begin lo = 64'd1;             hi = ALL_ONES; end
        default: begin
          lo = rand64() >> 8;
          hi = rand64() | 64'h8000_0000_0000_0000;
        end
      endcase
      write_reg(REG_RANGE_MIN, lo);
      write_reg(REG_RANGE_MAX, hi);
      if ($urandom_range(0, 1) == 1)
        queue_request(make_item(KIND_SEED, rand64(), 7'($urandom_range(0, 127))));
      repeat (20) queue_request(random_request());
    end

    wait_idle();
    if (mismatches == 0 && draws_owed.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/xrg_pkg.sv
src/xrg_datapath.sv
src/xrg_ctrl.sv
src/xoshiro256pp_range_generator.sv
tb/tb.sv
